@@ src/plte_pkg.sv @@
package plte_pkg;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PROBE,
        ST_COMPARE,
        ST_CLAMP,
        ST_RIGHT,
        ST_LEFT,
        ST_DIVIDE,
        ST_MULT,
        ST_FINISH,
        ST_RESPOND
    } state_t;

    localparam logic [1:0] CMD_CLEAR  = 2'd0;
    localparam logic [1:0] CMD_APPEND = 2'd1;
    localparam logic [1:0] CMD_EVAL   = 2'd2;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_FULL  = 2'd1;
    localparam logic [1:0] STATUS_EMPTY = 2'd2;

    localparam int DATA_W    = 32;
    localparam int FRAC_BITS = 16;
    localparam int STEP_W    = $clog2(FRAC_BITS);
    localparam int ACC_W     = DATA_W + 2;

endpackage

@@ src/plte_if.sv @@
interface plte_req_if;
    logic               valid;
    logic               ready;
    logic [1:0]         command;
    logic signed [31:0] coord_x;
    logic signed [31:0] coord_y;

    modport source (output valid, output command, output coord_x, output coord_y,
                    input ready);
    modport sink   (input valid, input command, input coord_x, input coord_y,
                    output ready);
endinterface

interface plte_rsp_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] value;
    logic [1:0]         status;

    modport source (output valid, output value, output status, input ready);
    modport sink   (input valid, input value, input status, output ready);
endinterface

@@ src/plte_ram.sv @@
module plte_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

@@ src/piecewise_linear_table_eval.sv @@
// channel | dir | payload                        | accepted when
// req     | in  | command, coord_x, coord_y      | req.valid && req.ready
// rsp     | out | value, status                  | rsp.valid && rsp.ready
//
// one request at a time; clear, append and no-op requests go straight from idle to the respond state
// evaluate: search probes over the single ram read port, each a read and a compare, ceil(log2(n+1))
// probes on a nondecreasing table and up to n probes once an out-of-order x was appended,
// then 2 reads and the bit-serial divider and multiplier; a clamped query takes one read
// and skips them, and both are also skipped when a segment end gives the value
// reset clears the point count and the response valid; table contents are not cleared
// a stalled response is held in its own register while the next request is taken

module piecewise_linear_table_eval #(
    parameter int MAX_POINTS = 256
) (
    input  logic       clk,
    input  logic       rst_n,
    plte_req_if.sink   req,
    plte_rsp_if.source rsp
);

    import plte_pkg::*;

    localparam int AW = $clog2(MAX_POINTS);
    localparam int CW = $clog2(MAX_POINTS + 1);
    localparam logic [CW-1:0]     FULL_COUNT = CW'(MAX_POINTS);
    localparam logic [STEP_W-1:0] LAST_STEP  = STEP_W'(FRAC_BITS - 1);

    state_t state_reg, state_next;

    logic [CW-1:0]              count_reg, count_next;
    logic                       sorted_reg, sorted_next;
    logic signed [DATA_W-1:0]   last_x_reg, last_x_next;
    logic signed [DATA_W-1:0]   q_reg, q_next;
    logic [CW-1:0]              lo_reg, lo_next;
    logic [CW-1:0]              hi_reg, hi_next;
    logic [AW-1:0]              mid_reg, mid_next;
    logic signed [DATA_W-1:0]   x1_reg, x1_next;
    logic signed [DATA_W-1:0]   y1_reg, y1_next;
    logic signed [DATA_W-1:0]   y0_reg, y0_next;
    logic signed [DATA_W:0]     len_reg, len_next;
    logic signed [DATA_W:0]     d_reg, d_next;
    logic [ACC_W-1:0]           acc_reg, acc_next;
    logic [FRAC_BITS-1:0]       frac_reg, frac_next;
    logic [STEP_W-1:0]          step_reg, step_next;
    logic [DATA_W-1:0]          val_reg, val_next;
    logic [1:0]                 sts_reg, sts_next;
    logic                       out_valid_reg, out_valid_next;
    logic [DATA_W-1:0]          out_value_reg, out_value_next;
    logic [1:0]                 out_status_reg, out_status_next;

    logic                       ram_we;
    logic                       ram_re;
    logic [AW-1:0]              ram_raddr;
    logic [2*DATA_W-1:0]        ram_rdata;

    logic                       in_ready;
    logic                       req_fire;
    logic                       out_free;
    logic signed [DATA_W-1:0]   in_x;
    logic signed [DATA_W-1:0]   rd_x;
    logic signed [DATA_W-1:0]   rd_y;
    logic [CW:0]                mid_sum;
    logic [CW-1:0]              mid_full;
    logic [CW-1:0]              lo_minus;
    logic [CW-1:0]              count_minus;
    logic                       x_ge_q;
    logic signed [DATA_W:0]     len_w;
    logic signed [DATA_W:0]     dq_w;
    logic signed [DATA_W:0]     d_w;
    logic                       left_only;
    logic                       right_only;
    logic [ACC_W-1:0]           shifted;
    logic [ACC_W-1:0]           len_ext;
    logic [ACC_W-1:0]           diff;
    logic                       quo_bit;
    logic [ACC_W-1:0]           d_ext;
    logic [ACC_W-1:0]           mac;

    plte_ram #(
        .WIDTH (2 * DATA_W),
        .DEPTH (MAX_POINTS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (count_reg[AW-1:0]),
        .wdata ({req.coord_x, req.coord_y}),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign in_ready  = (state_reg == ST_IDLE);
    assign req_fire  = req.valid && in_ready;
    assign out_free  = !out_valid_reg || rsp.ready;
    assign in_x      = req.coord_x;
    assign req.ready = in_ready;

    assign rsp.valid  = out_valid_reg;
    assign rsp.value  = out_value_reg;
    assign rsp.status = out_status_reg;

    assign rd_x = ram_rdata[2*DATA_W-1:DATA_W];
    assign rd_y = ram_rdata[DATA_W-1:0];

    // midpoint on a sorted table, plain forward scan otherwise
    assign mid_sum     = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign mid_full    = sorted_reg ? mid_sum[CW:1] : lo_reg;
    assign lo_minus    = lo_reg - CW'(1);
    assign count_minus = count_reg - CW'(1);
    assign x_ge_q      = (rd_x >= q_reg);

    assign len_w      = {x1_reg[DATA_W-1], x1_reg} - {rd_x[DATA_W-1], rd_x};
    assign dq_w       = {q_reg[DATA_W-1], q_reg} - {rd_x[DATA_W-1], rd_x};
    assign d_w        = {y1_reg[DATA_W-1], y1_reg} - {rd_y[DATA_W-1], rd_y};
    assign left_only  = (len_w <= 0) || (dq_w <= 0);
    assign right_only = (dq_w >= len_w);

    // restoring divide step, one quotient bit per cycle
    assign shifted = {acc_reg[ACC_W-2:0], 1'b0};
    assign len_ext = {1'b0, len_reg};
    assign quo_bit = (shifted >= len_ext);
    assign diff    = shifted - len_ext;

    // shift-add multiply step, fraction bits consumed lsb first
    assign d_ext = {d_reg[DATA_W], d_reg};
    assign mac   = frac_reg[0] ? (acc_reg + d_ext) : acc_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (req_fire)
                begin
                    if (req.command == CMD_EVAL && count_reg != '0)
                    begin
                        state_next = ST_PROBE;
                    end
                    else
                    begin
                        state_next = ST_RESPOND;
                    end
                end
            end
            ST_PROBE:
            begin
                if (lo_reg != hi_reg)
                begin
                    state_next = ST_COMPARE;
                end
                else if (lo_reg == '0 || lo_reg == count_reg)
                begin
                    state_next = ST_CLAMP;
                end
                else
                begin
                    state_next = ST_RIGHT;
                end
            end
            ST_COMPARE: state_next = ST_PROBE;
            ST_CLAMP:   state_next = ST_RESPOND;
            ST_RIGHT:   state_next = ST_LEFT;
            ST_LEFT:
            begin
                if (left_only || right_only)
                begin
                    state_next = ST_RESPOND;
                end
                else
                begin
                    state_next = ST_DIVIDE;
                end
            end
            ST_DIVIDE:
            begin
                if (step_reg == LAST_STEP)
                begin
                    state_next = ST_MULT;
                end
            end
            ST_MULT:
            begin
                if (step_reg == LAST_STEP)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:  state_next = ST_RESPOND;
            ST_RESPOND:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:    state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        count_next      = count_reg;
        sorted_next     = sorted_reg;
        last_x_next     = last_x_reg;
        q_next          = q_reg;
        lo_next         = lo_reg;
        hi_next         = hi_reg;
        mid_next        = mid_reg;
        x1_next         = x1_reg;
        y1_next         = y1_reg;
        y0_next         = y0_reg;
        len_next        = len_reg;
        d_next          = d_reg;
        acc_next        = acc_reg;
        frac_next       = frac_reg;
        step_next       = step_reg;
        val_next        = val_reg;
        sts_next        = sts_reg;
        out_valid_next  = out_valid_reg;
        out_value_next  = out_value_reg;
        out_status_next = out_status_reg;
        ram_we          = 1'b0;
        ram_re          = 1'b0;
        ram_raddr       = '0;

        if (out_valid_reg && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (req_fire)
                begin
                    val_next = '0;
                    sts_next = STATUS_OK;
                    case (req.command)
                        CMD_CLEAR:
                        begin
                            count_next  = '0;
                            sorted_next = 1'b1;
                        end
                        CMD_APPEND:
                        begin
                            if (count_reg == FULL_COUNT)
                            begin
                                sts_next = STATUS_FULL;
                            end
                            else
                            begin
                                ram_we      = 1'b1;
                                count_next  = count_reg + CW'(1);
                                last_x_next = in_x;
                                if (count_reg != '0 && in_x < last_x_reg)
                                begin
                                    sorted_next = 1'b0;
                                end
                            end
                        end
                        CMD_EVAL:
                        begin
                            if (count_reg == '0)
                            begin
                                sts_next = STATUS_EMPTY;
                            end
                            else
                            begin
                                q_next  = in_x;
                                lo_next = '0;
                                hi_next = count_reg;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_PROBE:
            begin
                ram_re = 1'b1;
                if (lo_reg != hi_reg)
                begin
                    ram_raddr = mid_full[AW-1:0];
                    mid_next  = mid_full[AW-1:0];
                end
                else if (lo_reg == count_reg)
                begin
                    // query above every x: last point
                    ram_raddr = count_minus[AW-1:0];
                end
                else
                begin
                    ram_raddr = lo_reg[AW-1:0];
                end
            end
            ST_COMPARE:
            begin
                if (x_ge_q)
                begin
                    hi_next = CW'(mid_reg);
                end
                else
                begin
                    lo_next = CW'(mid_reg) + CW'(1);
                end
            end
            ST_CLAMP:
            begin
                val_next = rd_y;
            end
            ST_RIGHT:
            begin
                x1_next   = rd_x;
                y1_next   = rd_y;
                ram_re    = 1'b1;
                ram_raddr = lo_minus[AW-1:0];
            end
            ST_LEFT:
            begin
                y0_next   = rd_y;
                len_next  = len_w;
                d_next    = d_w;
                acc_next  = {dq_w[DATA_W], dq_w};
                step_next = '0;
                frac_next = '0;
                if (left_only)
                begin
                    val_next = rd_y;
                end
                else if (right_only)
                begin
                    val_next = y1_reg;
                end
            end
            ST_DIVIDE:
            begin
                frac_next = {frac_reg[FRAC_BITS-2:0], quo_bit};
                acc_next  = quo_bit ? diff : shifted;
                step_next = step_reg + STEP_W'(1);
                if (step_reg == LAST_STEP)
                begin
                    // remainder done, register becomes the product accumulator
                    acc_next = '0;
                end
            end
            ST_MULT:
            begin
                acc_next  = {mac[ACC_W-1], mac[ACC_W-1:1]};
                frac_next = {mac[0], frac_reg[FRAC_BITS-1:1]};
                step_next = step_reg + STEP_W'(1);
            end
            ST_FINISH:
            begin
                // accumulator now holds floor(d * frac / 2^16)
                val_next = y0_reg + acc_reg[DATA_W-1:0];
            end
            ST_RESPOND:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_value_next  = val_reg;
                    out_status_next = sts_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            sorted_reg    <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            sorted_reg    <= sorted_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        last_x_reg     <= last_x_next;
        q_reg          <= q_next;
        lo_reg         <= lo_next;
        hi_reg         <= hi_next;
        mid_reg        <= mid_next;
        x1_reg         <= x1_next;
        y1_reg         <= y1_next;
        y0_reg         <= y0_next;
        len_reg        <= len_next;
        d_reg          <= d_next;
        acc_reg        <= acc_next;
        frac_reg       <= frac_next;
        step_reg       <= step_next;
        val_reg        <= val_next;
        sts_reg        <= sts_next;
        out_value_reg  <= out_value_next;
        out_status_reg <= out_status_next;
    end

endmodule

@@ src/plte_checker.sv @@
module plte_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        req_valid,
    input logic        req_ready,
    input logic        rsp_valid,
    input logic        rsp_ready,
    input logic [31:0] rsp_value,
    input logic [1:0]  rsp_status
);

    import plte_pkg::*;

    // a waiting response holds its payload
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_value) && $stable(rsp_status))
        else $error("response changed while stalled");

    // one request in flight at a time
    assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request taken while another is at work");

    // a fresh response comes only out of a busy cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> !$past(req_ready))
        else $error("response without a request");

    // refused append and empty evaluate carry a zero value
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp_status == STATUS_FULL || rsp_status == STATUS_EMPTY)
        |-> rsp_value == '0)
        else $error("error status with nonzero value");

endmodule

bind piecewise_linear_table_eval plte_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .req_valid  (req.valid),
    .req_ready  (req.ready),
    .rsp_valid  (rsp.valid),
    .rsp_ready  (rsp.ready),
    .rsp_value  (rsp.value),
    .rsp_status (rsp.status)
);

@@ verif/tb_piecewise_linear_table_eval.sv @@
`timescale 1ns / 1ps

module tb_piecewise_linear_table_eval;

    import plte_pkg::*;

    localparam int          TABLE_DEPTH  = 256;
    localparam int          RANDOM_ITEMS = 1600;
    localparam int          DIRECTED_MAX = 25;
    localparam int          DRAIN_CYCLES = 700;
    localparam longint      CYCLE_LIMIT  = 3_000_000;
    localparam logic [1:0]  CMD_NOP      = 2'd3;
    localparam logic [31:0] X_MIN        = 32'h8000_0000;
    localparam logic [31:0] X_MAX        = 32'h7fff_ffff;

    typedef struct {
        logic signed [31:0] value;
        logic [1:0]         status;
    } curve_result_t;

    class curve_scoreboard;
        logic signed [31:0] brk_x [TABLE_DEPTH];
        logic signed [31:0] brk_y [TABLE_DEPTH];
        int                 n_points;
        curve_result_t      pending_rsp [$];
        int                 errors;

        function new();
            n_points = 0;
            errors   = 0;
        endfunction

        // first stored x at or above q picks the right end of the segment
        function logic [31:0] interp_value(longint q);
            int     idx;
            longint x0, x1, y0, y1, seg_len, dq, frac, prod;
            if (n_points == 1)
                return brk_y[0];
            idx = 0;
            while (idx < n_points && longint'(brk_x[idx]) < q)
                idx++;
            if (idx == 0)
                return brk_y[0];
            if (idx >= n_points)
                return brk_y[n_points - 1];
            x0 = brk_x[idx - 1];
            x1 = brk_x[idx];
            y0 = brk_y[idx - 1];
            y1 = brk_y[idx];
            seg_len = x1 - x0;
            dq = q - x0;
            if (seg_len <= 0 || dq <= 0)
                return brk_y[idx - 1];
            if (dq >= seg_len)
                return brk_y[idx];
            frac = (dq <<< 16) / seg_len;
            prod = (y1 - y0) * frac;
            return 32'(y0 + (prod >>> 16));
        endfunction

        function void note_request(logic [1:0] cmd, logic signed [31:0] x,
                                   logic signed [31:0] y);
            curve_result_t res;
            res.value  = '0;
            res.status = STATUS_OK;
            case (cmd)
                CMD_CLEAR:
                begin
                    n_points = 0;
                end
                CMD_APPEND:
                begin
                    if (n_points >= TABLE_DEPTH)
                    begin
                        res.status = STATUS_FULL;
                    end
                    else
                    begin
                        brk_x[n_points] = x;
                        brk_y[n_points] = y;
                        n_points++;
                    end
                end
                CMD_EVAL:
                begin
                    if (n_points == 0)
                        res.status = STATUS_EMPTY;
                    else
                        res.value = interp_value(x);
                end
                default:
                begin
                end
            endcase
            pending_rsp.push_back(res);
        endfunction

        function void check_response(logic signed [31:0] value, logic [1:0] status);
            curve_result_t exp_res;
            if (pending_rsp.size() == 0)
            begin
                $error("response with no request outstanding: value %0d status %0d",
                       value, status);
                errors++;
                return;
            end
            exp_res = pending_rsp.pop_front();
            if (status !== exp_res.status)
            begin
                $error("status mismatch: expected %0d actual %0d", exp_res.status, status);
                errors++;
            end
            if (value !== exp_res.value)
            begin
                $error("value mismatch: expected %0d actual %0d", exp_res.value, value);
                errors++;
            end
        endfunction
    endclass

    logic   clk;
    logic   rst_n;
    longint cycle_cnt;
    int     req_sent;
    int     burst_left;
    int     stall_mode;
    int     mode_left;
    int     known_x [$];

    curve_scoreboard sb;

    plte_req_if req_ch ();
    plte_rsp_if rsp_ch ();

    piecewise_linear_table_eval #(
        .MAX_POINTS(TABLE_DEPTH)
    ) i_dut (
        .clk  (clk),
        .rst_n(rst_n),
        .req  (req_ch),
        .rsp  (rsp_ch)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    initial
    begin
        cycle_cnt  = 0;
        stall_mode = 0;
        mode_left  = 0;
    end

    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT)
        begin
            $display("tb_piecewise_linear_table_eval NOT OK");
            $finish;
        end
    end

    // receiver stall pattern, switching to a random mode whenever the mode counter runs out
    always @(negedge clk)
    begin
        if (mode_left == 0)
        begin
            stall_mode <= $urandom_range(0, 3);
            mode_left  <= $urandom_range(20, 300);
        end
        else
        begin
            mode_left <= mode_left - 1;
        end
        case (stall_mode)
            0:       rsp_ch.ready <= 1'b1;
            1:       rsp_ch.ready <= ($urandom_range(0, 1) == 1);
            2:       rsp_ch.ready <= ($urandom_range(0, 7) == 0);
            default: rsp_ch.ready <= ($urandom_range(0, 3) != 0);
        endcase
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
            sb.check_response(rsp_ch.value, rsp_ch.status);
    end

    task automatic issue(logic [1:0] cmd, logic [31:0] x, logic [31:0] y);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, ($urandom_range(0, 3) == 0) ? 60 : 12);
            gap = ($urandom_range(0, 4) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 4);
            repeat (gap)
            begin
                @(negedge clk);
                req_ch.valid   <= 1'b0;
                req_ch.command <= 2'($urandom_range(0, 3));
                req_ch.coord_x <= $urandom;
                req_ch.coord_y <= $urandom;
            end
        end
        burst_left--;
        @(negedge clk);
        req_ch.valid   <= 1'b1;
        req_ch.command <= cmd;
        req_ch.coord_x <= x;
        req_ch.coord_y <= y;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        sb.note_request(cmd, x, y);
        req_sent++;
    endtask

    task automatic wait_idle();
        @(negedge clk);
        req_ch.valid <= 1'b0;
        while (sb.pending_rsp.size() != 0)
            @(negedge clk);
        repeat ($urandom_range(1, 10))
            @(negedge clk);
    endtask

    function automatic logic [31:0] pick_y(int mode);
        case (mode)
            0:       return $urandom;
            1:       return 32'($urandom_range(0, 4000)) - 32'd2000;
            default: return ($urandom_range(0, 2) == 0) ? $urandom
                          : (($urandom_range(0, 1) == 0) ? X_MIN : X_MAX);
        endcase
    endfunction

    function automatic logic [31:0] pick_query();
        int              sorted_x [$];
        int              k;
        longint          lo, diff;
        longint unsigned off;
        int              r;
        r = $urandom_range(0, 9);
        if (known_x.size() == 0 || r == 0)
            return $urandom;
        if (r == 9)
            return ($urandom_range(0, 1) == 0) ? X_MIN : X_MAX;
        k = $urandom_range(0, known_x.size() - 1);
        if (r <= 2)
            return known_x[k];
        if (r == 3)
            return known_x[k] + (($urandom_range(0, 1) == 0) ? 1 : -1);
        sorted_x = known_x;
        sorted_x.sort();
        if (sorted_x.size() < 2)
            return sorted_x[0] + $urandom_range(0, 65536) - 32768;
        k = $urandom_range(0, sorted_x.size() - 2);
        lo = sorted_x[k];
        diff = longint'(sorted_x[k + 1]) - lo;
        if (diff <= 1)
            return sorted_x[k + 1];
        off = {$urandom, $urandom} % longint'(diff - 1);
        return 32'(lo + 1 + longint'(off));
    endfunction

    task automatic stray_request();
        int r;
        int sx;
        r = $urandom_range(0, 9);
        if (r <= 5)
        begin
            issue(CMD_NOP, $urandom, $urandom);
        end
        else if (r <= 7)
        begin
            issue(CMD_EVAL, $urandom, $urandom);
        end
        else if (r == 8)
        begin
            // append at a random x, which may break the order
            sx = $urandom;
            known_x.push_back(sx);
            issue(CMD_APPEND, sx, $urandom);
        end
        else
        begin
            known_x.delete();
            issue(CMD_CLEAR, $urandom, $urandom);
        end
    endtask

    task automatic load_points(int n, bit wide);
        int     pts [$];
        longint acc;
        int     step_bits;
        int     y_mode;
        int     i;
        if (wide)
        begin
            for (i = 0; i < n; i++)
                pts.push_back($urandom);
            pts.sort();
        end
        else
        begin
            acc = longint'(int'($urandom));
            step_bits = $urandom_range(0, 24);
            for (i = 0; i < n; i++)
            begin
                if (acc > 2147483647)
                    acc = 2147483647;
                pts.push_back(int'(acc));
                if ($urandom_range(0, 4) != 0)
                    acc += $urandom_range(1, 1 << step_bits);
            end
        end
        y_mode = $urandom_range(0, 2);
        for (i = 0; i < n; i++)
        begin
            if ($urandom_range(0, 24) == 0)
                pts[i] = $urandom;
            if ($urandom_range(0, 11) == 0)
                stray_request();
            known_x.push_back(pts[i]);
            issue(CMD_APPEND, pts[i], pick_y(y_mode));
        end
    endtask

    task automatic table_phase();
        int n;
        int n_eval;
        int r;
        if ($urandom_range(0, 5) != 0)
        begin
            known_x.delete();
            issue(CMD_CLEAR, $urandom, $urandom);
        end
        r = $urandom_range(0, 9);
        if (r == 0)
            n = 1;
        else if (r <= 7)
            n = $urandom_range(2, 12);
        else if (r == 8)
            n = $urandom_range(13, 40);
        else
            n = 0;
        load_points(n, $urandom_range(0, 1));
        n_eval = $urandom_range(3, 25);
        repeat (n_eval)
        begin
            if ($urandom_range(0, 11) == 0)
                stray_request();
            issue(CMD_EVAL, pick_query(), $urandom);
        end
    endtask

    task automatic fill_table_phase();
        known_x.delete();
        issue(CMD_CLEAR, 32'd0, 32'd0);
        load_points(TABLE_DEPTH, 1'b1);
        // appends past the last entry are refused
        repeat (4)
            issue(CMD_APPEND, $urandom, $urandom);
        repeat (20)
            issue(CMD_EVAL, pick_query(), $urandom);
    endtask

    task automatic run_directed();
        issue(CMD_EVAL, 32'd0, 32'd0);
        issue(CMD_NOP, 32'hffff_ffff, 32'hffff_ffff);
        issue(CMD_APPEND, X_MIN, X_MAX);
        issue(CMD_EVAL, X_MAX, 32'd0);
        issue(CMD_EVAL, X_MIN, 32'd0);
        // one segment spanning the whole range
        issue(CMD_APPEND, X_MAX, X_MIN);
        issue(CMD_EVAL, 32'd0, 32'd0);
        issue(CMD_EVAL, X_MAX, 32'd0);
        issue(CMD_EVAL, X_MIN + 32'd1, 32'd0);
        issue(CMD_CLEAR, 32'hffff_ffff, 32'hffff_ffff);
        issue(CMD_EVAL, 32'd0, 32'd0);
        // repeated x on both ends of a segment
        issue(CMD_APPEND, -32'sd65536, 32'd100);
        issue(CMD_APPEND, -32'sd65536, 32'd200);
        issue(CMD_APPEND, 32'd65536, -32'sd300);
        issue(CMD_APPEND, 32'd65536, 32'd5);
        issue(CMD_APPEND, 32'd131072, 32'd7 << 16);
        issue(CMD_EVAL, -32'sd65536, 32'd0);
        issue(CMD_EVAL, -32'sd65537, 32'd0);
        issue(CMD_EVAL, 32'd0, 32'd0);
        issue(CMD_EVAL, 32'd65536, 32'd0);
        issue(CMD_EVAL, 32'd65537, 32'd0);
        issue(CMD_EVAL, 32'd200000, 32'd0);
        // out-of-order point after the last one
        issue(CMD_APPEND, 32'd0, -32'sd1);
        issue(CMD_EVAL, 32'd100000, 32'd0);
        issue(CMD_EVAL, 32'd150000, 32'd0);
    endtask

    task automatic run_random();
        int phase_no;
        phase_no = 0;
        while (req_sent < DIRECTED_MAX + RANDOM_ITEMS)
        begin
            phase_no++;
            if (phase_no == 4)
                fill_table_phase();
            else if ($urandom_range(0, 11) == 0)
                table_phase();
            else
                table_phase();
            if (phase_no == 2 || $urandom_range(0, 7) == 0)
                wait_idle();
        end
    endtask

    initial
    begin
        sb             = new();
        req_sent       = 0;
        burst_left     = 0;
        req_ch.valid   = 1'b0;
        req_ch.command = CMD_CLEAR;
        req_ch.coord_x = '0;
        req_ch.coord_y = '0;
        rsp_ch.ready   = 1'b0;
        rst_n          = 1'b0;
        repeat (9)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        run_directed();
        wait_idle();
        run_random();
        @(negedge clk);
        req_ch.valid <= 1'b0;
        while (sb.pending_rsp.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);
        if (sb.errors == 0)
            $display("tb_piecewise_linear_table_eval OK");
        else
            $display("tb_piecewise_linear_table_eval NOT OK");
        $finish;
    end

endmodule

@@ files.f @@
src/plte_pkg.sv
src/plte_if.sv
src/plte_ram.sv
src/piecewise_linear_table_eval.sv
src/plte_checker.sv
verif/tb_piecewise_linear_table_eval.sv
